>>> rtl/core/http_request_line_checker_macros.svh
// ----------------------------------------------------------------------------
// http_request_line_checker_macros
// Assertion helpers for the request line checker.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_CHECKER_MACROS_SVH
`define HTTP_REQUEST_LINE_CHECKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define HRLC_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define HRLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/hrlc_pkg.sv
// ----------------------------------------------------------------------------
// hrlc_pkg
// Shared types, character codes and version matcher for the request line
// checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrlc_pkg;

    localparam int PATH_COUNT_BITS_DEF = 16;
    localparam int LEN_W               = 16;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [1:0] METHOD_LEN = 2'd3;

    localparam logic [3:0] VP_PREFIX_0  = 4'd0;
    localparam logic [3:0] VP_PREFIX_1  = 4'd1;
    localparam logic [3:0] VP_PREFIX_2  = 4'd2;
    localparam logic [3:0] VP_PREFIX_3  = 4'd3;
    localparam logic [3:0] VP_PREFIX_4  = 4'd4;
    localparam logic [3:0] VP_MAJOR_1ST = 4'd5;
    localparam logic [3:0] VP_MAJOR     = 4'd6;
    localparam logic [3:0] VP_MINOR_1ST = 4'd7;
    localparam logic [3:0] VP_MINOR     = 4'd8;
    localparam logic [3:0] VP_BAD       = 4'd9;

    typedef enum logic [2:0] {
        VERDICT_OK          = 3'd0,
        VERDICT_BAD_METHOD  = 3'd1,
        VERDICT_EMPTY_PATH  = 3'd2,
        VERDICT_NO_CRLF     = 3'd3,
        VERDICT_BAD_VERSION = 3'd4
    } verdict_t;

    typedef struct packed {
        logic                   request_ok;
        verdict_t               verdict;
        logic [LEN_W-1:0]       path_length;
    } result_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic [7:0] method_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = CH_G;
            2'd1:    c = CH_E;
            2'd2:    c = CH_T;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] version_take(input logic [3:0] p, input logic [7:0] b);
        logic [3:0] n;
        case (p)
            VP_PREFIX_0:  n = (b == CH_H)     ? VP_PREFIX_1  : VP_BAD;
            VP_PREFIX_1:  n = (b == CH_T)     ? VP_PREFIX_2  : VP_BAD;
            VP_PREFIX_2:  n = (b == CH_T)     ? VP_PREFIX_3  : VP_BAD;
            VP_PREFIX_3:  n = (b == CH_P)     ? VP_PREFIX_4  : VP_BAD;
            VP_PREFIX_4:  n = (b == CH_SLASH) ? VP_MAJOR_1ST : VP_BAD;
            VP_MAJOR_1ST: n = is_digit(b)     ? VP_MAJOR     : VP_BAD;
            VP_MAJOR:     n = is_digit(b) ? VP_MAJOR : ((b == CH_DOT) ? VP_MINOR_1ST : VP_BAD);
            VP_MINOR_1ST: n = is_digit(b)     ? VP_MINOR     : VP_BAD;
            VP_MINOR:     n = is_digit(b)     ? VP_MINOR     : VP_BAD;
            default:      n = VP_BAD;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/http_request_line_checker.sv
// ----------------------------------------------------------------------------
// http_request_line_checker
// Checks the request line of a message (GET method, non-empty path, HTTP/x.y
// version ended by CRLF) and reports one result per message.
//
// Byte channel: text_byte, end_of_message with byte_valid / byte_stall.
// Result channel: request_ok, verdict, path_length with result_valid /
// result_stall. Only the item marked end_of_message yields a result.
// Throughput: one item per cycle while no last byte waits for the result
// register; the parse update between the input register and the result
// register is combinational. A last byte is held in the input register,
// and result_valid rises once the result register is loaded.
// A result waiting under result_stall does not block bytes without
// end_of_message; a last byte waits in the input register, with
// byte_stall high, until the result register frees.
// Reset clears all parse state; the block is ready as soon as reset is
// released and starts each message in the method phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "http_request_line_checker_macros.svh"

module http_request_line_checker #(
    parameter int PATH_COUNT_BITS = hrlc_pkg::PATH_COUNT_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        byte_valid,
    output logic                             byte_stall,
    input  wire logic [7:0]                  text_byte,
    input  wire logic                        end_of_message,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic                             request_ok,
    output logic [2:0]                       verdict,
    output logic [hrlc_pkg::LEN_W-1:0]       path_length
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              accept;
    logic              advance;
    logic              out_ready;
    logic              res_valid;
    hrlc_pkg::result_t res;
    hrlc_pkg::result_t out_data;

    assign advance    = in_valid_reg && (!in_last_reg || out_ready);
    assign byte_stall = in_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= text_byte;
            in_last_reg <= end_of_message;
        end
    end

    hrlc_parse #(
        .PATH_COUNT_BITS (PATH_COUNT_BITS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (advance),
        .step_byte  (in_byte_reg),
        .step_last  (in_last_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    hrlc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_data (res),
        .stall     (result_stall),
        .valid     (result_valid),
        .ready     (out_ready),
        .data      (out_data)
    );

    assign request_ok  = out_data.request_ok;
    assign verdict     = out_data.verdict;
    assign path_length = out_data.path_length;

    `HRLC_ASSERT(a_ok_matches_verdict, result_valid, request_ok == (verdict == hrlc_pkg::VERDICT_OK), "request_ok disagrees with verdict")
    `HRLC_ASSERT(a_ok_has_path, result_valid && request_ok, path_length != '0, "accepted request with empty path")
    `HRLC_ASSERT_NEXT(a_hold_input, in_valid_reg && !advance, in_valid_reg, "input item lost while blocked")

endmodule

`default_nettype wire

>>> rtl/core/hrlc_parse.sv
// ----------------------------------------------------------------------------
// hrlc_parse
// Parse state and per-byte update; forms the result on the last byte of a
// message and returns to the start state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrlc_parse #(
    parameter int PATH_COUNT_BITS = hrlc_pkg::PATH_COUNT_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step_valid,
    input  wire logic [7:0]       step_byte,
    input  wire logic             step_last,
    output logic                  res_valid,
    output hrlc_pkg::result_t     res
);

    localparam int CNT_EXT_W = (PATH_COUNT_BITS > hrlc_pkg::LEN_W) ?
                               PATH_COUNT_BITS : hrlc_pkg::LEN_W;

    typedef enum logic [1:0] {
        PH_METHOD  = 2'd0,
        PH_PATH    = 2'd1,
        PH_VERSION = 2'd2
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [1:0]                 prog_reg, prog_next;
    logic                       mismatch_reg, mismatch_next;
    logic [PATH_COUNT_BITS-1:0] count_reg, count_next;
    logic [3:0]                 vphase_reg, vphase_next;
    logic                       cr_reg, cr_next;
    logic                       decided_reg, decided_next;
    hrlc_pkg::verdict_t         dverdict_reg, dverdict_next;
    logic                       ended_reg, ended_next;
    logic [3:0]                 vp;
    hrlc_pkg::verdict_t         verdict;
    logic [CNT_EXT_W-1:0]       count_ext;

    always_comb
    begin
        phase_next    = phase_reg;
        prog_next     = prog_reg;
        mismatch_next = mismatch_reg;
        count_next    = count_reg;
        vphase_next   = vphase_reg;
        cr_next       = cr_reg;
        decided_next  = decided_reg;
        dverdict_next = dverdict_reg;
        ended_next    = ended_reg;
        vp            = vphase_reg;

        if (step_valid && !ended_reg && !decided_reg)
        begin
            if (step_byte == hrlc_pkg::CH_NUL)
            begin
                ended_next = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_METHOD:
                    begin
                        if (step_byte == hrlc_pkg::CH_SP)
                        begin
                            if (mismatch_reg || (prog_reg != hrlc_pkg::METHOD_LEN))
                            begin
                                decided_next  = 1'b1;
                                dverdict_next = hrlc_pkg::VERDICT_BAD_METHOD;
                            end
                            else
                            begin
                                phase_next = PH_PATH;
                            end
                        end
                        else
                        begin
                            if ((prog_reg == hrlc_pkg::METHOD_LEN) ||
                                (step_byte != hrlc_pkg::method_char(prog_reg)))
                            begin
                                mismatch_next = 1'b1;
                            end
                            if (prog_reg != hrlc_pkg::METHOD_LEN)
                            begin
                                prog_next = prog_reg + 2'd1;
                            end
                        end
                    end
                    PH_PATH:
                    begin
                        if (step_byte == hrlc_pkg::CH_SP)
                        begin
                            if (count_reg == '0)
                            begin
                                decided_next  = 1'b1;
                                dverdict_next = hrlc_pkg::VERDICT_EMPTY_PATH;
                            end
                            else
                            begin
                                phase_next = PH_VERSION;
                            end
                        end
                        else if (count_reg != {PATH_COUNT_BITS{1'b1}})
                        begin
                            count_next = count_reg + PATH_COUNT_BITS'(1);
                        end
                    end
                    PH_VERSION:
                    begin
                        if (cr_reg && (step_byte == hrlc_pkg::CH_LF))
                        begin
                            cr_next       = 1'b0;
                            decided_next  = 1'b1;
                            if (vphase_reg == hrlc_pkg::VP_MINOR)
                            begin
                                dverdict_next = hrlc_pkg::VERDICT_OK;
                            end
                            else
                            begin
                                dverdict_next = hrlc_pkg::VERDICT_BAD_VERSION;
                            end
                        end
                        else
                        begin
                            // lone CR joins the version and can never match it
                            if (cr_reg)
                            begin
                                vp = hrlc_pkg::VP_BAD;
                            end
                            if (step_byte == hrlc_pkg::CH_CR)
                            begin
                                cr_next = 1'b1;
                            end
                            else
                            begin
                                cr_next = 1'b0;
                                vp      = hrlc_pkg::version_take(vp, step_byte);
                            end
                            vphase_next = vp;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        if (decided_next)
        begin
            verdict = dverdict_next;
        end
        else if (phase_next == PH_METHOD)
        begin
            verdict = hrlc_pkg::VERDICT_EMPTY_PATH;
        end
        else if ((phase_next == PH_PATH) && (count_next == '0))
        begin
            verdict = hrlc_pkg::VERDICT_EMPTY_PATH;
        end
        else
        begin
            verdict = hrlc_pkg::VERDICT_NO_CRLF;
        end
    end

    assign count_ext = CNT_EXT_W'(count_next);

    always_comb
    begin
        res_valid       = step_valid && step_last;
        res.request_ok  = (verdict == hrlc_pkg::VERDICT_OK);
        res.verdict     = verdict;
        res.path_length = (count_ext > CNT_EXT_W'({hrlc_pkg::LEN_W{1'b1}})) ?
                          {hrlc_pkg::LEN_W{1'b1}} : count_ext[hrlc_pkg::LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_METHOD;
            prog_reg     <= 2'd0;
            mismatch_reg <= 1'b0;
            count_reg    <= '0;
            vphase_reg   <= hrlc_pkg::VP_PREFIX_0;
            cr_reg       <= 1'b0;
            decided_reg  <= 1'b0;
            dverdict_reg <= hrlc_pkg::VERDICT_OK;
            ended_reg    <= 1'b0;
        end
        else if (step_valid && step_last)
        begin
            phase_reg    <= PH_METHOD;
            prog_reg     <= 2'd0;
            mismatch_reg <= 1'b0;
            count_reg    <= '0;
            vphase_reg   <= hrlc_pkg::VP_PREFIX_0;
            cr_reg       <= 1'b0;
            decided_reg  <= 1'b0;
            dverdict_reg <= hrlc_pkg::VERDICT_OK;
            ended_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            prog_reg     <= prog_next;
            mismatch_reg <= mismatch_next;
            count_reg    <= count_next;
            vphase_reg   <= vphase_next;
            cr_reg       <= cr_next;
            decided_reg  <= decided_next;
            dverdict_reg <= dverdict_next;
            ended_reg    <= ended_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hrlc_out_reg.sv
// ----------------------------------------------------------------------------
// hrlc_out_reg
// Result register; holds a result item until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrlc_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire hrlc_pkg::result_t  load_data,
    input  wire logic               stall,
    output logic                    valid,
    output logic                    ready,
    output hrlc_pkg::result_t       data
);

    logic              valid_reg, valid_next;
    hrlc_pkg::result_t data_reg;

    assign ready = !valid_reg || !stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire
